// ----- rtl/crpq_pkg.sv -----
// Shared types, codes and helper functions of the coalescing repeat packet queue.
package crpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int KIND_W    = 4;
  localparam int REPEAT_W  = 4;
  localparam int BYTES_W   = 3;
  localparam int PAYLOAD_W = 48;
  localparam int OCC_W     = 5;
  localparam int MODE_W    = 2;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMERG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic [KIND_W-1:0]    kind;
    logic [REPEAT_W-1:0]  repeat_cnt;
    logic [BYTES_W-1:0]   byte_count;
    logic [PAYLOAD_W-1:0] payload;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  len;
    logic              flush;
  } cfg_t;

  function automatic logic [CNT_W-1:0] ring_len(input logic [LEN_W-1:0] q);
    int unsigned l;
    l = int'(q);
    if (l == 0) begin
      l = 1;
    end else if (l > DEPTH) begin
      l = DEPTH;
    end
    return CNT_W'(l);
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] len);
    int unsigned n;
    n = int'(i) + 1;
    if (n >= int'(len)) begin
      return '0;
    end
    return IDX_W'(n);
  endfunction

endpackage

// ----- rtl/crpq_if.sv -----
// Channel interfaces of the coalescing repeat packet queue: input, result and configuration.
interface crpq_in_if
  import crpq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ADDR_W-1:0]    address;
  logic [KIND_W-1:0]    kind;
  logic [REPEAT_W-1:0]  repeat_req;
  logic [BYTES_W-1:0]   byte_count;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, operation, address, kind, repeat_req, byte_count, payload,
                  input ready);
  modport sink (input valid, operation, address, kind, repeat_req, byte_count, payload,
                output ready);
endinterface

interface crpq_out_if
  import crpq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 success;
  logic [ADDR_W-1:0]    out_address;
  logic [KIND_W-1:0]    out_kind;
  logic [REPEAT_W-1:0]  out_repeat;
  logic [BYTES_W-1:0]   out_byte_count;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [OCC_W-1:0]     occupancy;

  modport source (output valid, success, out_address, out_kind, out_repeat, out_byte_count,
                  out_payload, occupancy, input ready);
  modport sink (input valid, success, out_address, out_kind, out_repeat, out_byte_count,
                out_payload, occupancy, output ready);
endinterface

interface crpq_cfg_if
  import crpq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/crpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/crpq_core.sv -----
// Sequencer of the packet queue: ring pointers, one-entry-per-cycle coalescing scan and reads.
module crpq_core
  import crpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  crpq_in_if.sink           in_pkt,
  crpq_out_if.source        out_pkt,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output slot_t             ram_wdata,
  output logic [IDX_W-1:0]  ram_raddr,
  input  slot_t             ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FINISH} state_t;

  state_t               state;
  logic [IDX_W-1:0]     head_index;
  logic [IDX_W-1:0]     tail_index;
  logic [CNT_W-1:0]     held_count;
  slot_t                pkt;
  logic                 reinsert;
  logic [IDX_W-1:0]     issue_idx;
  logic [CNT_W-1:0]     issue_n;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  logic                 res_success;
  slot_t                res_slot;
  logic                 out_valid;
  logic                 out_success;
  slot_t                out_slot;
  logic [OCC_W-1:0]     out_occ;

  logic                 accept;
  logic                 match;
  logic                 issue_done;
  logic                 has_room;
  logic                 load_out;
  logic [REPEAT_W-1:0]  cnt_dec;
  slot_t                head_upd;

  assign in_pkt.ready = (state == S_IDLE);
  assign accept       = in_pkt.valid && in_pkt.ready;

  assign match = chk_vld && (ram_rdata.address == pkt.address) && (ram_rdata.kind == pkt.kind);
  assign issue_done = (issue_n == held_count);
  assign has_room   = (held_count < cfg.len);
  assign load_out   = (state == S_FINISH) && (!out_valid || out_pkt.ready);
  assign cnt_dec    = (ram_rdata.repeat_cnt == '0) ? '0 : ram_rdata.repeat_cnt - REPEAT_W'(1);

  always_comb begin
    head_upd = ram_rdata;
    head_upd.repeat_cnt = cnt_dec;
  end

  always_comb begin
    ram_raddr = (state == S_SCAN) ? issue_idx : head_index;
    ram_we    = 1'b0;
    ram_waddr = head_index;
    ram_wdata = head_upd;
    case (state)
      S_SCAN: begin
        if (match) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx;
          ram_wdata = pkt;
        end else if (issue_done && has_room) begin
          ram_we    = 1'b1;
          ram_waddr = tail_index;
          ram_wdata = pkt;
        end
      end
      S_READ: begin
        ram_we = (cfg.mode == MODE_EMERG);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign out_pkt.valid          = out_valid;
  assign out_pkt.success        = out_success;
  assign out_pkt.out_address    = out_slot.address;
  assign out_pkt.out_kind       = out_slot.kind;
  assign out_pkt.out_repeat     = out_slot.repeat_cnt;
  assign out_pkt.out_byte_count = out_slot.byte_count;
  assign out_pkt.out_payload    = out_slot.payload;
  assign out_pkt.occupancy      = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_index <= '0;
      tail_index <= '0;
      held_count <= '0;
      chk_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_pkt.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.flush) begin
        head_index <= '0;
        tail_index <= '0;
        held_count <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pkt.address    <= in_pkt.address;
            pkt.kind       <= in_pkt.kind;
            pkt.repeat_cnt <= in_pkt.repeat_req;
            pkt.byte_count <= in_pkt.byte_count;
            pkt.payload    <= in_pkt.payload;
            reinsert       <= 1'b0;
            res_success    <= 1'b0;
            res_slot       <= '0;
            issue_idx      <= head_index;
            issue_n        <= '0;
            chk_vld        <= 1'b0;
            case (in_pkt.operation)
              OP_INSERT: begin
                if (cfg.mode == MODE_REPEAT && in_pkt.repeat_req == '0) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_READ: begin
                state <= (held_count == '0) ? S_FINISH : S_READ;
              end
              OP_CLEAR: begin
                head_index <= '0;
                tail_index <= '0;
                held_count <= '0;
                state      <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_READ: begin
          res_success <= 1'b1;
          if (cfg.mode == MODE_REPEAT) begin
            res_slot   <= head_upd;
            head_index <= ring_next(head_index, cfg.len);
            held_count <= held_count - CNT_W'(1);
            if (cnt_dec != '0) begin
              pkt       <= head_upd;
              reinsert  <= 1'b1;
              issue_idx <= ring_next(head_index, cfg.len);
              issue_n   <= '0;
              chk_vld   <= 1'b0;
              state     <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end else if (cfg.mode == MODE_EMERG) begin
            res_slot <= head_upd;
            state    <= S_FINISH;
            if (cnt_dec == '0) begin
              head_index <= ring_next(head_index, cfg.len);
              held_count <= held_count - CNT_W'(1);
            end
          end else begin
            res_slot   <= ram_rdata;
            head_index <= ring_next(head_index, cfg.len);
            held_count <= held_count - CNT_W'(1);
            state      <= S_FINISH;
          end
        end
        S_SCAN: begin
          if (match) begin
            if (!reinsert) begin
              res_success <= 1'b1;
            end
            chk_vld <= 1'b0;
            state   <= S_FINISH;
          end else if (issue_done) begin
            if (has_room) begin
              tail_index <= ring_next(tail_index, cfg.len);
              held_count <= held_count + CNT_W'(1);
              if (!reinsert) begin
                res_success <= 1'b1;
              end
            end
            chk_vld <= 1'b0;
            state   <= S_FINISH;
          end else begin
            chk_vld   <= 1'b1;
            chk_idx   <= issue_idx;
            issue_idx <= ring_next(issue_idx, cfg.len);
            issue_n   <= issue_n + CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (load_out) begin
            out_success <= res_success;
            out_slot    <= res_slot;
            out_occ     <= OCC_W'(held_count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_held_in_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= cfg.len)
    else $error("Queue holds more entries than the ring length.");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (head_index < cfg.len) && (tail_index < cfg.len))
    else $error("Ring pointer beyond the ring length.");

  a_held_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (held_count == $past(held_count)) || (held_count == '0) ||
                    (held_count == $past(held_count) + CNT_W'(1)) ||
                    (held_count == $past(held_count) - CNT_W'(1)))
    else $error("Occupancy changed by more than one entry.");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SCAN || state == S_READ))
    else $error("Slot write outside a scan or read.");

endmodule

// ----- rtl/coalescing_repeat_packet_queue_top.sv -----
// Top level of the coalescing repeat packet queue: configuration registers, sequencer and slot RAM.
//
// A ring queue of up to DEPTH command packets. Each transfer on in_pkt is one operation
// (insert, read or clear) and yields exactly one transfer on out_pkt. The block is busy
// while an operation runs and accepts a new one once the previous result is registered,
// even if that result has not yet been taken. An insert compares one slot per cycle
// against the new address and kind with a single comparator on the slot RAM read port.
// In repeat mode a read whose packet still has repeats left re-inserts it through the
// same scan.
// Configuration writes are taken at any time but must only be made while the queue is
// idle; writing queue_length empties the queue.
module coalescing_repeat_packet_queue_top
  import crpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  crpq_cfg_if.sink    cfg,
  crpq_in_if.sink     in_pkt,
  crpq_out_if.source  out_pkt
);

  logic [MODE_W-1:0] queue_mode;
  logic [LEN_W-1:0]  queue_length;
  cfg_t              core_cfg;
  logic              cfg_accept;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  slot_t             ram_rdata;

  assign cfg.ready  = 1'b1;
  assign cfg_accept = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode   <= MODE_PLAIN;
      queue_length <= LEN_RESET;
    end else if (cfg_accept) begin
      case (cfg.index)
        REG_MODE: begin
          queue_mode <= cfg.data[MODE_W-1:0];
        end
        REG_LENGTH: begin
          queue_length <= cfg.data[LEN_W-1:0];
        end
        default: begin
          queue_mode <= queue_mode;
        end
      endcase
    end
  end

  assign core_cfg.mode  = queue_mode;
  assign core_cfg.len   = ring_len(queue_length);
  assign core_cfg.flush = cfg_accept && (cfg.index == REG_LENGTH);

  crpq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (core_cfg),
    .in_pkt    (in_pkt),
    .out_pkt   (out_pkt),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  crpq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- dv/coalescing_repeat_packet_queue_top_tb.sv -----
// Self-checking testbench of the coalescing repeat packet queue: predictor, scoreboard and drivers.
module coalescing_repeat_packet_queue_top_tb;
  import crpq_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNKNOWN = 2'd3;
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 115;
  localparam int POOL_SIZE      = 6;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_WAIT       = 40;
  localparam int KEEP_LENGTH    = -1;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [ADDR_W-1:0]    address;
    logic [KIND_W-1:0]    kind;
    logic [REPEAT_W-1:0]  repeat_req;
    logic [BYTES_W-1:0]   byte_count;
    logic [PAYLOAD_W-1:0] payload;
  } packet_req_t;

  typedef struct packed {
    logic                 success;
    logic [ADDR_W-1:0]    address;
    logic [KIND_W-1:0]    kind;
    logic [REPEAT_W-1:0]  rpt;
    logic [BYTES_W-1:0]   byte_count;
    logic [PAYLOAD_W-1:0] payload;
    logic [OCC_W-1:0]     occupancy;
  } packet_result_t;

  class coalescing_queue_scoreboard;
    slot_t             slots[DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       held;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  length;
    packet_result_t    due_results[$];
    int                errors;
    int                checked;

    function new();
      mode = MODE_PLAIN;
      length = LEN_RESET;
      head = 0;
      tail = 0;
      held = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned span();
      if (length == 0) return 1;
      if (length > DEPTH) return DEPTH;
      return length;
    endfunction

    function int unsigned advance(int unsigned i);
      return (i + 1 >= span()) ? 0 : i + 1;
    endfunction

    function bit place(slot_t s);
      int unsigned i;
      int unsigned n;
      i = head;
      for (n = 0; n < held; n++) begin
        if (slots[i].address == s.address && slots[i].kind == s.kind) begin
          slots[i] = s;
          return 1'b1;
        end
        i = advance(i);
      end
      if (held >= span()) return 1'b0;
      slots[tail] = s;
      tail = advance(tail);
      held++;
      return 1'b1;
    endfunction

    function void pop_head();
      head = advance(head);
      if (held > 0) held--;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MODE) begin
        mode = data[MODE_W-1:0];
      end else if (idx == REG_LENGTH) begin
        length = data[LEN_W-1:0];
        head = 0;
        tail = 0;
        held = 0;
      end
    endfunction

    function void note_input(packet_req_t req);
      packet_result_t     res;
      slot_t              s;
      logic [MODE_W-1:0]  m;
      logic [REPEAT_W-1:0] cnt;
      res = '0;
      m = (mode == MODE_ALIAS) ? MODE_PLAIN : mode;
      case (req.operation)
        OP_INSERT: begin
          s.address = req.address;
          s.kind = req.kind;
          s.repeat_cnt = req.repeat_req;
          s.byte_count = req.byte_count;
          s.payload = req.payload;
          if (m == MODE_REPEAT && req.repeat_req == 0) res.success = 1'b0;
          else res.success = place(s);
        end
        OP_READ: begin
          if (held > 0) begin
            s = slots[head];
            cnt = s.repeat_cnt;
            res.success = 1'b1;
            res.address = s.address;
            res.kind = s.kind;
            res.byte_count = s.byte_count;
            res.payload = s.payload;
            if (m == MODE_PLAIN) begin
              pop_head();
            end else if (m == MODE_REPEAT) begin
              // The packet goes back through the coalescing insert while repeats remain.
              pop_head();
              if (cnt != 0) begin
                cnt = cnt - 1'b1;
                if (cnt != 0) begin
                  s.repeat_cnt = cnt;
                  void'(place(s));
                end
              end
            end else begin
              if (cnt != 0) cnt = cnt - 1'b1;
              slots[head].repeat_cnt = cnt;
              if (cnt == 0) pop_head();
            end
            res.rpt = cnt;
          end
        end
        OP_CLEAR: begin
          head = 0;
          tail = 0;
          held = 0;
        end
        default: begin
        end
      endcase
      res.occupancy = OCC_W'(held);
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(packet_result_t got);
      packet_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %0h", $time, got);
        return;
      end
      want = due_results.pop_front();
      checked++;
      compare_field("success", want.success, got.success);
      compare_field("out_address", want.address, got.address);
      compare_field("out_kind", want.kind, got.kind);
      compare_field("out_repeat", want.rpt, got.rpt);
      compare_field("out_byte_count", want.byte_count, got.byte_count);
      compare_field("out_payload", want.payload, got.payload);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  crpq_cfg_if cfg_if ();
  crpq_in_if  in_if ();
  crpq_out_if out_if ();

  coalescing_repeat_packet_queue_top u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .in_pkt  (in_if),
    .out_pkt (out_if)
  );

  coalescing_queue_scoreboard sb = new();

  bit                in_up;
  bit                hold_req;
  int                n_inserts;
  int                n_reads;
  int                n_clears;
  int                n_unknown;
  int                n_cfg;
  logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
  logic [KIND_W-1:0] pool_kind[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic packet_req_t make_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                           logic [KIND_W-1:0] k, logic [REPEAT_W-1:0] r,
                                           logic [BYTES_W-1:0] b, logic [PAYLOAD_W-1:0] p);
    packet_req_t req;
    req.operation = op;
    req.address = a;
    req.kind = k;
    req.repeat_req = r;
    req.byte_count = b;
    req.payload = p;
    return req;
  endfunction

  function automatic packet_req_t random_request();
    packet_req_t req;
    int          pick;
    int          slot;
    pick = $urandom_range(0, 99);
    if (pick < 48) req.operation = OP_INSERT;
    else if (pick < 90) req.operation = OP_READ;
    else if (pick < 96) req.operation = OP_CLEAR;
    else req.operation = OP_UNKNOWN;
    // Mostly reuse a few address and kind pairs so that inserts coalesce.
    pick = $urandom_range(0, 9);
    slot = $urandom_range(0, POOL_SIZE - 1);
    req.address = (pick < 8) ? pool_addr[slot] : ADDR_W'($urandom_range(0, 65535));
    req.kind = (pick < 7) ? pool_kind[slot] : KIND_W'($urandom_range(0, 15));
    if ($urandom_range(0, 3) != 0)
      req.repeat_req = REPEAT_W'($urandom_range((sb.mode == MODE_REPEAT) ? 1 : 0, 3));
    else
      req.repeat_req = REPEAT_W'($urandom_range(0, 15));
    req.byte_count = BYTES_W'($urandom_range(0, 7));
    req.payload = PAYLOAD_W'({$urandom, $urandom});
    return req;
  endfunction

  task automatic send_item(input packet_req_t req);
    in_if.valid <= 1'b1;
    in_if.operation <= req.operation;
    in_if.address <= req.address;
    in_if.kind <= req.kind;
    in_if.repeat_req <= req.repeat_req;
    in_if.byte_count <= req.byte_count;
    in_if.payload <= req.payload;
    in_up = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(req);
    case (req.operation)
      OP_INSERT: n_inserts++;
      OP_READ:   n_reads++;
      OP_CLEAR:  n_clears++;
      default:   n_unknown++;
    endcase
  endtask

  task automatic idle_in();
    if (in_up) begin
      in_if.valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  task automatic wait_all_results();
    idle_in();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, data);
    n_cfg++;
  endtask

  task automatic end_cfg();
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: checks each transfer and stalls on a pattern that changes over time.
  initial begin
    int unsigned    cyc;
    int unsigned    hold_left;
    packet_result_t got;
    cyc = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready) begin
        got.success = out_if.success;
        got.address = out_if.out_address;
        got.kind = out_if.out_kind;
        got.rpt = out_if.out_repeat;
        got.byte_count = out_if.out_byte_count;
        got.payload = out_if.out_payload;
        got.occupancy = out_if.occupancy;
        sb.check_result(got);
      end
      cyc++;
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case ((cyc / 200) % 4)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= cyc[3];
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                lengths[RANDOM_PHASES];
    logic [MODE_W-1:0] modes[4];
    int                burst_left;
    int                ph;
    int                k;
    int                i;
    lengths = '{16, 1, 31, 2, 0, 10, KEEP_LENGTH, 17, 4, 8, 3, KEEP_LENGTH};
    modes = '{MODE_PLAIN, MODE_REPEAT, MODE_EMERG, MODE_ALIAS};
    burst_left = 0;
    in_up = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_INSERT;
    in_if.address <= '0;
    in_if.kind <= '0;
    in_if.repeat_req <= '0;
    in_if.byte_count <= '0;
    in_if.payload <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_MODE;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Single-entry ring: full insert, coalescing, empty read, clear and unknown operation.
    write_cfg(REG_LENGTH, CFG_DATA_W'(1));
    write_cfg(REG_MODE, CFG_DATA_W'(MODE_PLAIN));
    end_cfg();
    send_item(make_req(OP_INSERT, 16'hFFFF, 4'hF, 4'hF, 3'd7, '1));
    send_item(make_req(OP_INSERT, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_INSERT, 16'hFFFF, 4'hF, 4'h3, 3'd6, 48'h0123_4567_89AB));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'hFFFF, 4'hF, 4'hF, 3'd7, '1));
    send_item(make_req(OP_INSERT, 16'h8001, 4'h8, 4'h1, 3'd1, 48'h8000_0000_0001));
    send_item(make_req(OP_CLEAR, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_UNKNOWN, 16'hFFFF, 4'hF, 4'hF, 3'd7, '1));

    // Repeat mode: zero count refused, recirculation and drop on reaching zero.
    wait_all_results();
    write_cfg(REG_MODE, CFG_DATA_W'(MODE_REPEAT));
    write_cfg(REG_LENGTH, CFG_DATA_W'(16));
    end_cfg();
    send_item(make_req(OP_INSERT, 16'h0001, 4'h2, 4'h0, 3'd2, 48'hAAAA_5555_AAAA));
    send_item(make_req(OP_INSERT, 16'h1234, 4'h5, 4'h2, 3'd3, 48'h1111_2222_3333));
    send_item(make_req(OP_INSERT, 16'h1234, 4'h6, 4'h1, 3'd4, 48'h4444_5555_6666));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));

    // Emergency mode: a zero head count saturates and pops.
    wait_all_results();
    write_cfg(REG_MODE, CFG_DATA_W'(MODE_EMERG));
    end_cfg();
    send_item(make_req(OP_INSERT, 16'h00A5, 4'h3, 4'h0, 3'd5, 48'h5A5A_5A5A_5A5A));
    send_item(make_req(OP_INSERT, 16'h5A00, 4'hC, 4'h2, 3'd6, 48'hFEDC_BA98_7654));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));

    // Mode three and a length of zero, which acts as one entry.
    wait_all_results();
    write_cfg(REG_MODE, CFG_DATA_W'(MODE_ALIAS));
    write_cfg(REG_LENGTH, CFG_DATA_W'(0));
    end_cfg();
    send_item(make_req(OP_INSERT, 16'h7FFF, 4'h7, 4'h9, 3'd4, 48'h7FFF_FFFF_FFFF));
    send_item(make_req(OP_INSERT, 16'h7FFE, 4'h7, 4'h9, 3'd4, 48'h0000_0000_0001));
    send_item(make_req(OP_READ, 16'h0000, 4'h0, 4'h0, 3'd0, '0));

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_all_results();
      for (i = 0; i < POOL_SIZE; i++) begin
        pool_addr[i] = ADDR_W'($urandom_range(0, 65535));
        pool_kind[i] = KIND_W'($urandom_range(0, 15));
      end
      write_cfg(REG_MODE, {3'($urandom_range(0, 7)), modes[ph % 4]});
      if (lengths[ph] != KEEP_LENGTH) write_cfg(REG_LENGTH, CFG_DATA_W'(lengths[ph]));
      end_cfg();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          idle_in();
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
        if (ph == 3 && k == 20) hold_req = 1'b1;
        if (ph == 7 && k == 60) wait_all_results();
        send_item(random_request());
        burst_left--;
      end
    end

    wait_all_results();
    repeat (END_WAIT) @(posedge clk);
    $display("Checked %0d results from %0d inserts, %0d reads, %0d clears, %0d unknown ops",
             sb.checked, n_inserts, n_reads, n_clears, n_unknown);
    $display("across all four modes and %0d register writes, ring lengths 0 to 31", n_cfg);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
